// ===== rtl/cpcr_pkg.sv =====
// Package for the circle pair collision resolver: widths, constants, the
// record types that travel down the pipeline and the saturation helper.
// Depends on nothing; every other file of the block uses it.
package cpcr_pkg;

  localparam int POS_W      = 32;
  localparam int RAD_W      = 16;
  localparam int SQ_W       = 50;
  localparam int DIST_W     = 25;
  localparam int SQRT_STEPS = 25;
  localparam int DIV_STEPS  = 31;
  localparam int REM_W      = 27;
  localparam int Q_W        = 31;

  // 0.01 in unsigned Q32.32, as the single-precision constant rounds.
  localparam logic [64:0] MIN_DIST_SQR      = 65'd42949672;
  localparam logic [15:0] RESTITUTION_RESET = 16'd32768;
  localparam logic [16:0] RESTITUTION_BIAS  = 17'd32768;

  typedef struct packed {
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] vel_x;
    logic signed [POS_W-1:0] vel_y;
  } body_t;

  typedef struct packed {
    body_t                 a;
    body_t                 b;
    logic                  hit;
    logic [DIST_W-1:0]     mind;
    logic signed [POS_W:0] rv_x;
    logic signed [POS_W:0] rv_y;
    logic                  neg_x;
    logic                  neg_y;
    logic [POS_W-1:0]      mag_x;
    logic [POS_W-1:0]      mag_y;
  } carry_t;

  typedef struct packed {
    body_t a;
    body_t b;
    logic  contact;
  } res_t;

  function automatic logic signed [POS_W-1:0] sat32(input logic signed [65:0] v);
    logic signed [POS_W-1:0] r;
    if (v > 66'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -66'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[POS_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/cpcr_if.sv =====
// Channel interfaces of the circle pair collision resolver: input pair,
// resolved result and the restitution write port. Uses cpcr_pkg widths.
interface cpcr_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [cpcr_pkg::POS_W-1:0] a_pos_x;
  logic signed [cpcr_pkg::POS_W-1:0] a_pos_y;
  logic signed [cpcr_pkg::POS_W-1:0] a_vel_x;
  logic signed [cpcr_pkg::POS_W-1:0] a_vel_y;
  logic [cpcr_pkg::RAD_W-1:0]        a_radius;
  logic signed [cpcr_pkg::POS_W-1:0] b_pos_x;
  logic signed [cpcr_pkg::POS_W-1:0] b_pos_y;
  logic signed [cpcr_pkg::POS_W-1:0] b_vel_x;
  logic signed [cpcr_pkg::POS_W-1:0] b_vel_y;
  logic [cpcr_pkg::RAD_W-1:0]        b_radius;
  modport source(output valid, a_pos_x, a_pos_y, a_vel_x, a_vel_y, a_radius,
                 b_pos_x, b_pos_y, b_vel_x, b_vel_y, b_radius, input ready);
  modport sink(input valid, a_pos_x, a_pos_y, a_vel_x, a_vel_y, a_radius,
               b_pos_x, b_pos_y, b_vel_x, b_vel_y, b_radius, output ready);
endinterface

interface cpcr_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [cpcr_pkg::POS_W-1:0] new_a_pos_x;
  logic signed [cpcr_pkg::POS_W-1:0] new_a_pos_y;
  logic signed [cpcr_pkg::POS_W-1:0] new_a_vel_x;
  logic signed [cpcr_pkg::POS_W-1:0] new_a_vel_y;
  logic signed [cpcr_pkg::POS_W-1:0] new_b_pos_x;
  logic signed [cpcr_pkg::POS_W-1:0] new_b_pos_y;
  logic signed [cpcr_pkg::POS_W-1:0] new_b_vel_x;
  logic signed [cpcr_pkg::POS_W-1:0] new_b_vel_y;
  logic                              contact;
  modport source(output valid, new_a_pos_x, new_a_pos_y, new_a_vel_x, new_a_vel_y,
                 new_b_pos_x, new_b_pos_y, new_b_vel_x, new_b_vel_y, contact,
                 input ready);
  modport sink(input valid, new_a_pos_x, new_a_pos_y, new_a_vel_x, new_a_vel_y,
               new_b_pos_x, new_b_pos_y, new_b_vel_x, new_b_vel_y, contact,
               output ready);
endinterface

interface cpcr_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;
  modport source(output valid, data, input ready);
  modport sink(input valid, data, output ready);
endinterface

// ===== rtl/cpcr_sqrt_step.sv =====
// One digit stage of the pipelined integer square root.
// Depends on cpcr_pkg for the operand width.
module cpcr_sqrt_step #(
  parameter int BitPos = 0
) (
  input  logic                      clk,
  input  logic                      en,
  input  logic [cpcr_pkg::SQ_W-1:0] x_i,
  input  logic [cpcr_pkg::SQ_W-1:0] res_i,
  output logic [cpcr_pkg::SQ_W-1:0] x_o,
  output logic [cpcr_pkg::SQ_W-1:0] res_o
);

  localparam logic [cpcr_pkg::SQ_W-1:0] Bit =
    {{(cpcr_pkg::SQ_W-1){1'b0}}, 1'b1} << BitPos;

  logic [cpcr_pkg::SQ_W-1:0] trial;
  logic [cpcr_pkg::SQ_W-1:0] x_nxt, res_nxt;
  logic [cpcr_pkg::SQ_W-1:0] x_r, res_r;

  always_comb begin
    trial = res_i + Bit;
    if (x_i >= trial) begin
      x_nxt   = x_i - trial;
      res_nxt = (res_i >> 1) + Bit;
    end else begin
      x_nxt   = x_i;
      res_nxt = res_i >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r   <= x_nxt;
      res_r <= res_nxt;
    end
  end

  assign x_o   = x_r;
  assign res_o = res_r;

endmodule

// ===== rtl/cpcr_div_step.sv =====
// One quotient-bit stage of the two restoring dividers that form the unit
// normal; both components share the divisor. Depends on cpcr_pkg.
module cpcr_div_step (
  input  logic                        clk,
  input  logic                        en,
  input  logic [cpcr_pkg::DIST_W-1:0] dist_i,
  input  logic [cpcr_pkg::REM_W-1:0]  rem_x_i,
  input  logic [cpcr_pkg::REM_W-1:0]  rem_y_i,
  input  logic [cpcr_pkg::Q_W-1:0]    q_x_i,
  input  logic [cpcr_pkg::Q_W-1:0]    q_y_i,
  output logic [cpcr_pkg::DIST_W-1:0] dist_o,
  output logic [cpcr_pkg::REM_W-1:0]  rem_x_o,
  output logic [cpcr_pkg::REM_W-1:0]  rem_y_o,
  output logic [cpcr_pkg::Q_W-1:0]    q_x_o,
  output logic [cpcr_pkg::Q_W-1:0]    q_y_o
);

  logic [cpcr_pkg::REM_W-1:0]  dv, rx, ry;
  logic                        gx, gy;
  logic [cpcr_pkg::DIST_W-1:0] dist_r;
  logic [cpcr_pkg::REM_W-1:0]  rem_x_r, rem_y_r;
  logic [cpcr_pkg::Q_W-1:0]    q_x_r, q_y_r;

  always_comb begin
    dv = {{(cpcr_pkg::REM_W-cpcr_pkg::DIST_W){1'b0}}, dist_i};
    gx = rem_x_i >= dv;
    gy = rem_y_i >= dv;
    rx = gx ? rem_x_i - dv : rem_x_i;
    ry = gy ? rem_y_i - dv : rem_y_i;
  end

  // The remainder is shifted here, so the next stage compares at once.
  always_ff @(posedge clk) begin
    if (en) begin
      dist_r  <= dist_i;
      rem_x_r <= {rx[cpcr_pkg::REM_W-2:0], 1'b0};
      rem_y_r <= {ry[cpcr_pkg::REM_W-2:0], 1'b0};
      q_x_r   <= {q_x_i[cpcr_pkg::Q_W-2:0], gx};
      q_y_r   <= {q_y_i[cpcr_pkg::Q_W-2:0], gy};
    end
  end

  assign dist_o  = dist_r;
  assign rem_x_o = rem_x_r;
  assign rem_y_o = rem_y_r;
  assign q_x_o   = q_x_r;
  assign q_y_o   = q_y_r;

endmodule

// ===== rtl/cpcr_out_fifo.sv =====
// Two-entry result queue that decouples the pipeline from the receiver.
// Depends on cpcr_pkg for the result record.
module cpcr_out_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  cpcr_pkg::res_t   push_data,
  input  logic             pop,
  output logic             full,
  output logic             not_empty,
  output cpcr_pkg::res_t   head
);

  cpcr_pkg::res_t mem [0:1];
  logic           wr_ptr_r, rd_ptr_r;
  logic [1:0]     count_r;
  logic           do_pop;

  assign do_pop    = pop && (count_r != 2'd0);
  assign full      = count_r == 2'd2;
  assign not_empty = count_r != 2'd0;
  assign head      = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      count_r <= count_r + {1'b0, push} - {1'b0, do_pop};
    end
  end

endmodule

// ===== rtl/circle_pair_collision_resolver_core.sv =====
// Circle pair collision resolver, top level.
// Channels: in_chan takes one circle pair per request, out_chan returns one
// resolved pair per request in the same order, cfg_chan writes the
// restitution coefficient (unsigned Q1.15) and is always ready.
// Throughput: one pair per cycle while the output queue is not full. The
// pipeline holds the 25-stage square root and the 31-stage normal
// dividers, plus the squaring, impulse multiply and saturation stages
// around them.
// All stages advance together; they hold while the two-entry output queue
// is full, so a stalled receiver loses and repeats nothing, and a new pair
// is still accepted while one result waits to be taken.
// Reset (rst_n, synchronous, active low) empties the pipeline and the queue
// and sets restitution to 1.0 (32768). Write restitution only while the
// block is idle.
// Depends on cpcr_pkg, cpcr_if, cpcr_sqrt_step, cpcr_div_step and
// cpcr_out_fifo.
module circle_pair_collision_resolver_core (
  input  logic        clk,
  input  logic        rst_n,
  cpcr_in_if.sink     in_chan,
  cpcr_out_if.source  out_chan,
  cpcr_cfg_if.sink    cfg_chan
);

  localparam int CN = cpcr_pkg::SQRT_STEPS + cpcr_pkg::DIV_STEPS + 1;
  localparam int VN = CN + 7;

  logic                  adv;
  logic                  q_full;
  logic [VN-1:0]         vld_r;
  logic [15:0]           rest_r;

  // Restitution register.
  assign cfg_chan.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rest_r <= cpcr_pkg::RESTITUTION_RESET;
    end else if (cfg_chan.valid) begin
      rest_r <= cfg_chan.data;
    end
  end

  assign adv           = !q_full;
  assign in_chan.ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[VN-2:0], in_chan.valid};
    end
  end

  // Stage 1: differences, magnitudes, radius sum, relative velocity.
  cpcr_pkg::carry_t        c1_nxt, c1_r;
  logic signed [31:0]      dx, dy;

  always_comb begin
    dx = cpcr_pkg::sat32(66'(in_chan.b_pos_x) - 66'(in_chan.a_pos_x));
    dy = cpcr_pkg::sat32(66'(in_chan.b_pos_y) - 66'(in_chan.a_pos_y));
    c1_nxt.a.pos_x = in_chan.a_pos_x;
    c1_nxt.a.pos_y = in_chan.a_pos_y;
    c1_nxt.a.vel_x = in_chan.a_vel_x;
    c1_nxt.a.vel_y = in_chan.a_vel_y;
    c1_nxt.b.pos_x = in_chan.b_pos_x;
    c1_nxt.b.pos_y = in_chan.b_pos_y;
    c1_nxt.b.vel_x = in_chan.b_vel_x;
    c1_nxt.b.vel_y = in_chan.b_vel_y;
    c1_nxt.hit     = 1'b0;
    c1_nxt.mind    = {17'({1'b0, in_chan.a_radius} + {1'b0, in_chan.b_radius}), 8'd0};
    c1_nxt.rv_x    = 33'(in_chan.a_vel_x) - 33'(in_chan.b_vel_x);
    c1_nxt.rv_y    = 33'(in_chan.a_vel_y) - 33'(in_chan.b_vel_y);
    c1_nxt.neg_x   = dx[31];
    c1_nxt.neg_y   = dy[31];
    // The magnitude of the most negative value wraps to 2^31, as wanted.
    c1_nxt.mag_x   = dx[31] ? 32'(-dx) : 32'(dx);
    c1_nxt.mag_y   = dy[31] ? 32'(-dy) : 32'(dy);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c1_r <= c1_nxt;
    end
  end

  // Stage 2: exact squares.
  cpcr_pkg::carry_t c2_r;
  logic [63:0]      sqx_r, sqy_r;
  logic [49:0]      mindsq_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      c2_r     <= c1_r;
      sqx_r    <= 64'(c1_r.mag_x) * 64'(c1_r.mag_x);
      sqy_r    <= 64'(c1_r.mag_y) * 64'(c1_r.mag_y);
      mindsq_r <= 50'(c1_r.mind) * 50'(c1_r.mind);
    end
  end

  // Stage 3: contact test; the square root starts from this register.
  cpcr_pkg::carry_t          c_r [0:CN-1];
  cpcr_pkg::carry_t          c3_nxt;
  logic [64:0]               dsq;
  logic [cpcr_pkg::SQ_W-1:0] s3_x_r;
  logic [cpcr_pkg::SQ_W-1:0] sq_x   [0:cpcr_pkg::SQRT_STEPS];
  logic [cpcr_pkg::SQ_W-1:0] sq_res [0:cpcr_pkg::SQRT_STEPS];

  assign dsq = 65'(sqx_r) + 65'(sqy_r);

  always_comb begin
    c3_nxt     = c2_r;
    c3_nxt.hit = (dsq > cpcr_pkg::MIN_DIST_SQR) && (dsq < 65'(mindsq_r));
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_r[0] <= c3_nxt;
      s3_x_r <= dsq[cpcr_pkg::SQ_W-1:0];
    end
  end

  assign sq_x[0]   = s3_x_r;
  assign sq_res[0] = '0;

  genvar gi;
  generate
    for (gi = 1; gi < CN; gi++) begin : g_carry
      always_ff @(posedge clk) begin
        if (adv) begin
          c_r[gi] <= c_r[gi-1];
        end
      end
    end

    for (gi = 0; gi < cpcr_pkg::SQRT_STEPS; gi++) begin : g_sqrt
      cpcr_sqrt_step #(
        .BitPos(2 * (cpcr_pkg::SQRT_STEPS - 1 - gi))
      ) u_step (
        .clk  (clk),
        .en   (adv),
        .x_i  (sq_x[gi]),
        .res_i(sq_res[gi]),
        .x_o  (sq_x[gi+1]),
        .res_o(sq_res[gi+1])
      );
    end
  endgenerate

  // Normal dividers: magnitude * 2^30 / distance, one quotient bit a stage.
  localparam int SE = cpcr_pkg::SQRT_STEPS;
  logic [cpcr_pkg::DIST_W-1:0] dv_w  [0:cpcr_pkg::DIV_STEPS];
  logic [cpcr_pkg::REM_W-1:0]  rx_w  [0:cpcr_pkg::DIV_STEPS];
  logic [cpcr_pkg::REM_W-1:0]  ry_w  [0:cpcr_pkg::DIV_STEPS];
  logic [cpcr_pkg::Q_W-1:0]    qx_w  [0:cpcr_pkg::DIV_STEPS];
  logic [cpcr_pkg::Q_W-1:0]    qy_w  [0:cpcr_pkg::DIV_STEPS];

  assign dv_w[0] = sq_res[SE][cpcr_pkg::DIST_W-1:0];
  assign rx_w[0] = {2'b00, c_r[SE].mag_x[cpcr_pkg::DIST_W-1:0]};
  assign ry_w[0] = {2'b00, c_r[SE].mag_y[cpcr_pkg::DIST_W-1:0]};
  assign qx_w[0] = '0;
  assign qy_w[0] = '0;

  generate
    for (gi = 0; gi < cpcr_pkg::DIV_STEPS; gi++) begin : g_div
      cpcr_div_step u_step (
        .clk    (clk),
        .en     (adv),
        .dist_i (dv_w[gi]),
        .rem_x_i(rx_w[gi]),
        .rem_y_i(ry_w[gi]),
        .q_x_i  (qx_w[gi]),
        .q_y_i  (qy_w[gi]),
        .dist_o (dv_w[gi+1]),
        .rem_x_o(rx_w[gi+1]),
        .rem_y_o(ry_w[gi+1]),
        .q_x_o  (qx_w[gi+1]),
        .q_y_o  (qy_w[gi+1])
      );
    end
  endgenerate

  // M1: signed normal, velocity and penetration products.
  cpcr_pkg::carry_t   ce;
  logic signed [31:0] nx, ny;
  logic signed [26:0] pen;
  cpcr_pkg::res_t     m1_r, m2_r, m3_r, m4_r, m5_r;
  logic signed [31:0] nx1_r, ny1_r, nx2_r, ny2_r, nx3_r, ny3_r, nx4_r, ny4_r;
  logic signed [64:0] px_r, py_r;
  logic signed [58:0] cpx_r, cpy_r;

  assign ce  = c_r[CN-1];
  assign nx  = ce.neg_x ? -32'(qx_w[cpcr_pkg::DIV_STEPS]) : 32'(qx_w[cpcr_pkg::DIV_STEPS]);
  assign ny  = ce.neg_y ? -32'(qy_w[cpcr_pkg::DIV_STEPS]) : 32'(qy_w[cpcr_pkg::DIV_STEPS]);
  assign pen = 27'({2'b00, ce.mind}) - 27'({2'b00, dv_w[cpcr_pkg::DIV_STEPS]});

  always_ff @(posedge clk) begin
    if (adv) begin
      m1_r  <= {ce.a, ce.b, ce.hit};
      nx1_r <= nx;
      ny1_r <= ny;
      px_r  <= 65'(ce.rv_x) * 65'(nx);
      py_r  <= 65'(ce.rv_y) * 65'(ny);
      cpx_r <= 59'(pen) * 59'(nx);
      cpy_r <= 59'(pen) * 59'(ny);
    end
  end

  // M2: relative normal velocity and position corrections, floored.
  logic signed [65:0] vsum;
  logic signed [35:0] vrel_r;
  logic signed [27:0] cx_r, cy_r, cx3_r, cy3_r, cx4_r, cy4_r, cx5_r, cy5_r;

  assign vsum = 66'(px_r) + 66'(py_r);

  always_ff @(posedge clk) begin
    if (adv) begin
      m2_r   <= m1_r;
      nx2_r  <= nx1_r;
      ny2_r  <= ny1_r;
      vrel_r <= 36'(vsum >>> 30);
      cx_r   <= 28'(cpx_r >>> 31);
      cy_r   <= 28'(cpy_r >>> 31);
    end
  end

  // M3: scale by (1 + e) in Q1.15 terms.
  logic signed [17:0] kmul;
  logic signed [53:0] vk_r;

  assign kmul = signed'({1'b0, 17'(cpcr_pkg::RESTITUTION_BIAS + 17'(rest_r))});

  always_ff @(posedge clk) begin
    if (adv) begin
      m3_r  <= m2_r;
      nx3_r <= nx2_r;
      ny3_r <= ny2_r;
      cx3_r <= cx_r;
      cy3_r <= cy_r;
      vk_r  <= 54'(vrel_r) * 54'(kmul);
    end
  end

  // M4: impulse magnitude, negated before the floor shift.
  logic signed [54:0] vk_neg;
  logic signed [31:0] j_r;

  assign vk_neg = -55'(vk_r);

  always_ff @(posedge clk) begin
    if (adv) begin
      m4_r  <= m3_r;
      nx4_r <= nx3_r;
      ny4_r <= ny3_r;
      cx4_r <= cx3_r;
      cy4_r <= cy3_r;
      j_r   <= cpcr_pkg::sat32(66'(vk_neg >>> 16));
    end
  end

  // M5: impulse along the normal.
  logic signed [63:0] ipx_r, ipy_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      m5_r  <= m4_r;
      cx5_r <= cx4_r;
      cy5_r <= cy4_r;
      ipx_r <= 64'(j_r) * 64'(nx4_r);
      ipy_r <= 64'(j_r) * 64'(ny4_r);
    end
  end

  // Final update with saturation, written into the output queue.
  logic signed [33:0] ix, iy;
  cpcr_pkg::res_t     res;

  always_comb begin
    ix  = 34'(ipx_r >>> 30);
    iy  = 34'(ipy_r >>> 30);
    res = m5_r;
    if (m5_r.contact) begin
      res.a.vel_x = cpcr_pkg::sat32(66'(m5_r.a.vel_x) + 66'(ix));
      res.a.vel_y = cpcr_pkg::sat32(66'(m5_r.a.vel_y) + 66'(iy));
      res.b.vel_x = cpcr_pkg::sat32(66'(m5_r.b.vel_x) - 66'(ix));
      res.b.vel_y = cpcr_pkg::sat32(66'(m5_r.b.vel_y) - 66'(iy));
      res.a.pos_x = cpcr_pkg::sat32(66'(m5_r.a.pos_x) - 66'(cx5_r));
      res.a.pos_y = cpcr_pkg::sat32(66'(m5_r.a.pos_y) - 66'(cy5_r));
      res.b.pos_x = cpcr_pkg::sat32(66'(m5_r.b.pos_x) + 66'(cx5_r));
      res.b.pos_y = cpcr_pkg::sat32(66'(m5_r.b.pos_y) + 66'(cy5_r));
    end
  end

  cpcr_pkg::res_t head;

  cpcr_out_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (adv && vld_r[VN-1]),
    .push_data(res),
    .pop      (out_chan.ready),
    .full     (q_full),
    .not_empty(out_chan.valid),
    .head     (head)
  );

  assign out_chan.new_a_pos_x = head.a.pos_x;
  assign out_chan.new_a_pos_y = head.a.pos_y;
  assign out_chan.new_a_vel_x = head.a.vel_x;
  assign out_chan.new_a_vel_y = head.a.vel_y;
  assign out_chan.new_b_pos_x = head.b.pos_x;
  assign out_chan.new_b_pos_y = head.b.pos_y;
  assign out_chan.new_b_vel_x = head.b.vel_x;
  assign out_chan.new_b_vel_y = head.b.vel_y;
  assign out_chan.contact     = head.contact;

endmodule

// ===== sim/testbench.sv =====
// Testbench for circle_pair_collision_resolver_core: random and directed circle
// pairs with random idling on both sides, checked against a local collision model.
// Depends on cpcr_pkg, cpcr_if and the block's RTL.
module testbench;

  typedef struct {
    logic signed [31:0] apx, apy, avx, avy;
    logic [15:0]        ar;
    logic signed [31:0] bpx, bpy, bvx, bvy;
    logic [15:0]        br;
  } pair_t;

  typedef struct {
    logic signed [31:0] v[8];
    logic               contact;
  } resolved_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  cpcr_in_if  in_chan();
  cpcr_out_if out_chan();
  cpcr_cfg_if cfg_chan();

  circle_pair_collision_resolver_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_chan(in_chan.sink), .out_chan(out_chan.source), .cfg_chan(cfg_chan.sink)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  pair_t     pending_pairs[$];
  resolved_t expected_pairs[$];
  logic [15:0] restitution_coef = cpcr_pkg::RESTITUTION_RESET;
  logic [15:0] cfg_pending[$];
  int  error_count = 0;
  bit  hold_sender = 0;
  bit  steady = 0;

  function automatic logic signed [63:0] sat_word(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Floor division by a power of two; arithmetic shift floors already.
  function automatic logic signed [63:0] floor_div2(input logic signed [63:0] v, input int s);
    return v >>> s;
  endfunction

  function automatic logic [63:0] int_sqrt(input logic [63:0] x);
    logic [63:0] res, bit_v;
    res = 0;
    bit_v = 64'd1 << 62;
    while (bit_v > x) bit_v = bit_v >> 2;
    while (bit_v != 0) begin
      if (x >= res + bit_v) begin
        x = x - (res + bit_v);
        res = (res >> 1) + bit_v;
      end else begin
        res = res >> 1;
      end
      bit_v = bit_v >> 2;
    end
    return res;
  endfunction

  function automatic logic signed [63:0] unit_comp(input logic signed [63:0] c,
                                                   input logic [63:0] root_d);
    logic [63:0] mag, q;
    mag = c < 0 ? -c : c;
    q = (mag << 30) / root_d;
    return c < 0 ? -$signed(q) : $signed(q);
  endfunction

  function automatic resolved_t resolve_pair(input pair_t p, input logic [15:0] rest);
    resolved_t r;
    logic signed [63:0] dx, dy, nx, ny, rvx, rvy, vrel, k, j, ix, iy, pen, cx, cy;
    logic [63:0] dsq, mind, mindsq, root_d, ax, ay;
    dx = sat_word(64'(p.bpx) - 64'(p.apx));
    dy = sat_word(64'(p.bpy) - 64'(p.apy));
    ax = dx < 0 ? -dx : dx;
    ay = dy < 0 ? -dy : dy;
    dsq = ax * ax + ay * ay;
    mind = (64'(p.ar) + 64'(p.br)) << 8;
    mindsq = mind * mind;
    r.v[0] = p.apx; r.v[1] = p.apy; r.v[2] = p.avx; r.v[3] = p.avy;
    r.v[4] = p.bpx; r.v[5] = p.bpy; r.v[6] = p.bvx; r.v[7] = p.bvy;
    r.contact = 1'b0;
    if (dsq > 64'(cpcr_pkg::MIN_DIST_SQR) && dsq < mindsq) begin
      root_d = int_sqrt(dsq);
      nx = unit_comp(dx, root_d);
      ny = unit_comp(dy, root_d);
      rvx = 64'(p.avx) - 64'(p.bvx);
      rvy = 64'(p.avy) - 64'(p.bvy);
      vrel = floor_div2(rvx * nx + rvy * ny, 30);
      k = 64'sd32768 + $signed({48'd0, rest});
      j = sat_word(floor_div2(-(vrel * k), 16));
      ix = floor_div2(j * nx, 30);
      iy = floor_div2(j * ny, 30);
      pen = $signed(mind) - $signed(root_d);
      cx = floor_div2(pen * nx, 31);
      cy = floor_div2(pen * ny, 31);
      r.v[2] = 32'(sat_word(64'(p.avx) + ix));
      r.v[3] = 32'(sat_word(64'(p.avy) + iy));
      r.v[6] = 32'(sat_word(64'(p.bvx) - ix));
      r.v[7] = 32'(sat_word(64'(p.bvy) - iy));
      r.v[0] = 32'(sat_word(64'(p.apx) - cx));
      r.v[1] = 32'(sat_word(64'(p.apy) - cy));
      r.v[4] = 32'(sat_word(64'(p.bpx) + cx));
      r.v[5] = 32'(sat_word(64'(p.bpy) + cy));
      r.contact = 1'b1;
    end
    return r;
  endfunction

  function automatic logic signed [31:0] rand_word();
    return $signed($urandom());
  endfunction

  // Mostly overlapping pairs near a random center, a few far apart or odd.
  function automatic pair_t make_pair();
    pair_t p;
    int sel;
    logic signed [31:0] cxp, cyp;
    sel = $urandom_range(0, 9);
    cxp = $signed($urandom_range(0, 32'h3fffffff)) - 32'sh20000000;
    cyp = $signed($urandom_range(0, 32'h3fffffff)) - 32'sh20000000;
    if (sel < 7) begin
      p.ar = 16'($urandom_range(1, sel < 5 ? 16'h0800 : 16'hffff));
      p.br = 16'($urandom_range(1, sel < 5 ? 16'h0800 : 16'hffff));
      p.apx = cxp;
      p.apy = cyp;
      p.bpx = cxp + $signed($urandom_range(0, 32'h00100000)) - 32'sh00080000;
      p.bpy = cyp + $signed($urandom_range(0, 32'h00100000)) - 32'sh00080000;
      if (sel == 6) begin
        p.bpx = cxp + $signed($urandom_range(0, 1000)) - 500;
        p.bpy = cyp + $signed($urandom_range(0, 1000)) - 500;
      end
      p.avx = $signed($urandom_range(0, 32'h01ffffff)) - 32'sh01000000;
      p.avy = $signed($urandom_range(0, 32'h01ffffff)) - 32'sh01000000;
      p.bvx = $signed($urandom_range(0, 32'h01ffffff)) - 32'sh01000000;
      p.bvy = $signed($urandom_range(0, 32'h01ffffff)) - 32'sh01000000;
      if (sel == 5) begin
        p.avx = rand_word(); p.avy = rand_word();
        p.bvx = rand_word(); p.bvy = rand_word();
      end
    end else begin
      p.apx = rand_word(); p.apy = rand_word(); p.avx = rand_word();
      p.avy = rand_word(); p.ar = 16'($urandom()); p.bpx = rand_word();
      p.bpy = rand_word(); p.bvx = rand_word(); p.bvy = rand_word();
      p.br = 16'($urandom());
    end
    return p;
  endfunction

  function automatic pair_t fixed_pair(input logic signed [31:0] apx, apy, avx, avy,
                                       input logic [15:0] ar,
                                       input logic signed [31:0] bpx, bpy, bvx, bvy,
                                       input logic [15:0] br);
    pair_t p;
    p.apx = apx; p.apy = apy; p.avx = avx; p.avy = avy; p.ar = ar;
    p.bpx = bpx; p.bpy = bpy; p.bvx = bvx; p.bvy = bvy; p.br = br;
    return p;
  endfunction

  task automatic wait_idle();
    while (pending_pairs.size() != 0 || expected_pairs.size() != 0 || in_chan.valid)
      @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_restitution(input logic [15:0] val);
    cfg_pending.push_back(val);
    while (cfg_pending.size() != 0 || cfg_chan.valid) @(posedge clk);
  endtask

  // Configuration driver; only written while the pair pipeline is drained.
  always @(posedge clk) begin
    if (!rst_n) begin
      cfg_chan.valid <= 1'b0;
      cfg_chan.data  <= '0;
    end else if (cfg_chan.valid && cfg_chan.ready) begin
      restitution_coef = cfg_chan.data;
      if (cfg_pending.size() != 0) begin
        cfg_chan.data <= cfg_pending.pop_front();
      end else begin
        cfg_chan.valid <= 1'b0;
      end
    end else if (!cfg_chan.valid && cfg_pending.size() != 0) begin
      cfg_chan.valid <= 1'b1;
      cfg_chan.data  <= cfg_pending.pop_front();
    end
  end

  // Request driver. The prediction is made at acceptance with the current register.
  always @(posedge clk) begin
    pair_t p;
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
      {in_chan.a_pos_x, in_chan.a_pos_y, in_chan.a_vel_x, in_chan.a_vel_y} <= '0;
      {in_chan.b_pos_x, in_chan.b_pos_y, in_chan.b_vel_x, in_chan.b_vel_y} <= '0;
      in_chan.a_radius <= '0;
      in_chan.b_radius <= '0;
    end else begin
      if (in_chan.valid && in_chan.ready) begin
        p = fixed_pair(in_chan.a_pos_x, in_chan.a_pos_y, in_chan.a_vel_x,
                       in_chan.a_vel_y, in_chan.a_radius, in_chan.b_pos_x,
                       in_chan.b_pos_y, in_chan.b_vel_x, in_chan.b_vel_y,
                       in_chan.b_radius);
        expected_pairs.push_back(resolve_pair(p, restitution_coef));
      end
      if (!in_chan.valid || in_chan.ready) begin
        if (pending_pairs.size() != 0 && !hold_sender &&
            (steady || $urandom_range(0, 99) >= 38)) begin
          p = pending_pairs.pop_front();
          in_chan.valid    <= 1'b1;
          in_chan.a_pos_x  <= p.apx;
          in_chan.a_pos_y  <= p.apy;
          in_chan.a_vel_x  <= p.avx;
          in_chan.a_vel_y  <= p.avy;
          in_chan.a_radius <= p.ar;
          in_chan.b_pos_x  <= p.bpx;
          in_chan.b_pos_y  <= p.bpy;
          in_chan.b_vel_x  <= p.bvx;
          in_chan.b_vel_y  <= p.bvy;
          in_chan.b_radius <= p.br;
        end else begin
          in_chan.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and receiver stalls.
  always @(posedge clk) begin
    resolved_t e;
    logic signed [31:0] got[8];
    string names[8];
    names = '{"new_a_pos_x", "new_a_pos_y", "new_a_vel_x", "new_a_vel_y",
              "new_b_pos_x", "new_b_pos_y", "new_b_vel_x", "new_b_vel_y"};
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else begin
      if (out_chan.valid && out_chan.ready) begin
        got = '{out_chan.new_a_pos_x, out_chan.new_a_pos_y, out_chan.new_a_vel_x,
                out_chan.new_a_vel_y, out_chan.new_b_pos_x, out_chan.new_b_pos_y,
                out_chan.new_b_vel_x, out_chan.new_b_vel_y};
        if (expected_pairs.size() == 0) begin
          $error("unexpected result request");
          error_count++;
        end else begin
          e = expected_pairs.pop_front();
          for (int i = 0; i < 8; i++) begin
            if (got[i] !== e.v[i]) begin
              $error("%s expected %0d actual %0d", names[i], e.v[i], got[i]);
              error_count++;
            end
          end
          if (out_chan.contact !== e.contact) begin
            $error("contact expected %0b actual %0b", e.contact, out_chan.contact);
            error_count++;
          end
        end
      end
      out_chan.ready <= steady || $urandom_range(0, 99) >= 38;
    end
  end

  initial begin
    logic [15:0] settings[5];
    settings = '{16'd0, 16'hffff, 16'd32768, 16'd1, 16'h7fff};
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // Directed: touching, coincident, tiny offset, zero radii, extremes.
    pending_pairs.push_back(fixed_pair(0, 0, 32'sh10000, 0, 16'h0100,
                                       32'sh10000, 0, -32'sh10000, 0, 16'h0100));
    pending_pairs.push_back(fixed_pair(100, 100, 5, 6, 16'h0100, 100, 100, 7, 8, 16'h0100));
    pending_pairs.push_back(fixed_pair(0, 0, 0, 0, 16'h0100, 6553, 0, 0, 0, 16'h0100));
    pending_pairs.push_back(fixed_pair(0, 0, 0, 0, 16'h0100, 6554, 0, 0, 0, 16'h0100));
    pending_pairs.push_back(fixed_pair(0, 0, 0, 0, 16'h0100, 6554, 6554, 0, 0, 16'h0100));
    pending_pairs.push_back(fixed_pair(0, 0, 1, 1, 16'd0, 16, 0, 1, 1, 16'd0));
    pending_pairs.push_back(fixed_pair(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
                                       32'sh7fffffff, 16'hffff, 32'sh7fff0000,
                                       32'sh7fff0000, 32'sh80000000, 32'sh80000000,
                                       16'hffff));
    pending_pairs.push_back(fixed_pair(32'sh80000000, 32'sh80000000, 32'sh80000000,
                                       32'sh80000000, 16'hffff, 32'sh80010000,
                                       32'sh80000000, 32'sh7fffffff, 32'sh7fffffff,
                                       16'hffff));
    pending_pairs.push_back(fixed_pair(32'sh80000000, 0, 0, 0, 16'hffff,
                                       32'sh7fffffff, 0, 0, 0, 16'hffff));
    pending_pairs.push_back(fixed_pair(0, 0, 32'sh7fffffff, 0, 16'h8000, 32'sh00010000,
                                       32'sh00010000, 32'sh80000000, 0, 16'h8000));
    pending_pairs.push_back(fixed_pair(0, 0, -32'sh30000, 32'sh20000, 16'h0200,
                                       -32'sh18000, 32'sh8000, 0, 0, 16'h0180));
    wait_idle();
    for (int s = 0; s < 5; s++) begin
      write_restitution(settings[s]);
      steady = (s == 2);
      for (int n = 0; n < 120; n++) pending_pairs.push_back(make_pair());
      if (s == 3) begin
        while (pending_pairs.size() > 60) @(posedge clk);
        hold_sender = 1;
        while (expected_pairs.size() != 0 || in_chan.valid) @(posedge clk);
        hold_sender = 0;
      end
      wait_idle();
    end
    write_restitution(16'($urandom()));
    for (int n = 0; n < 20; n++) pending_pairs.push_back(make_pair());
    wait_idle();
    if (error_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("testbench: done, errors");
    $finish;
  end

endmodule
